FILE: hdl/telnet_login_line_parser_assert.svh
// assertion macros used by the telnet login line parser checker
`ifndef TELNET_LOGIN_LINE_PARSER_ASSERT_SVH
`define TELNET_LOGIN_LINE_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define TLP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("telnet login parser: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define TLP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("telnet login parser: next-cycle check failed");

`endif

FILE: hdl/tlp_pkg.sv
// shared codes and constants of the telnet login line parser
package tlp_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [2:0] t_event_code;
    typedef logic [1:0] t_stage;
    typedef logic [1:0] t_esc;

    // input commands
    localparam t_cmd CMD_BYTE       = 2'd0;
    localparam t_cmd CMD_TICK       = 2'd1;
    localparam t_cmd CMD_CONNECT    = 2'd2;
    localparam t_cmd CMD_DISCONNECT = 2'd3;

    // result kinds
    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // session event codes
    localparam t_event_code EV_NONE         = 3'd0;
    localparam t_event_code EV_PROMPT       = 3'd1;
    localparam t_event_code EV_ASK_PASS     = 3'd2;
    localparam t_event_code EV_LOGIN_OK     = 3'd3;
    localparam t_event_code EV_BAD_USER     = 3'd4;
    localparam t_event_code EV_BAD_PASS     = 3'd5;
    localparam t_event_code EV_KICK_ATTEMPT = 3'd6;
    localparam t_event_code EV_KICK_TIMEOUT = 3'd7;

    // authentication stages
    localparam t_stage ST_USER = 2'd0;
    localparam t_stage ST_PASS = 2'd1;
    localparam t_stage ST_IN   = 2'd2;

    // telnet escape tracking
    localparam t_esc ESC_NONE = 2'd0;
    localparam t_esc ESC_IAC  = 2'd1;
    localparam t_esc ESC_OPT  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_USER_TEXT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_TEXT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

    // configuration reset values
    localparam logic [7:0]  MAX_ATT_RST = 8'd3;
    localparam logic [15:0] TIMEOUT_RST = 16'd30000;

    // character codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_IAC    = 8'hFF;
    localparam logic [7:0] CH_OPT_LO = 8'd251;
    localparam logic [7:0] CH_OPT_HI = 8'd254;

endpackage

FILE: hdl/telnet_login_line_parser.sv
// telnet login line parser: escape filter, line editor and credential check
// flow: an accepted item's results are staged in the result buffer, then moved into the output
//   register; further results follow one a cycle while the output moves
// input: stalled outside idle, until the last result of an item is in the output register;
//   end of line first walks the stored line through the line memory port, one read a cycle
// reset: synchronous active low; clears session and configuration, line memory is not cleared
module telnet_login_line_parser
    import tlp_pkg::*;
#(
    parameter int LINE_DEPTH = 64,
    parameter int CRED_CHARS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_data_byte,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output logic [7:0]            o_echo_byte,
    output logic [2:0]            o_event_code,
    output logic                  o_logged_in,
    output logic                  o_last,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(LINE_DEPTH);
    localparam logic [3:0]    CRED_LEN = 4'(CRED_CHARS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    // configuration registers
    logic [63:0] r_user_text, r_pass_text;
    logic [3:0]  r_user_len, r_pass_len;
    logic [7:0]  r_max_att;
    logic [15:0] r_timeout;

    // session state
    t_state        r_state, n_state;
    t_stage        r_auth, n_auth;
    t_esc          r_esc, n_esc;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_failed, n_failed;
    logic [15:0]   r_ticks, n_ticks;
    logic          r_open, n_open;

    // result buffer
    logic          r_res_kind [0:2];
    logic [7:0]    r_res_byte [0:2];
    t_event_code   r_res_code [0:2];
    logic          n_res_kind [0:2];
    logic [7:0]    n_res_byte [0:2];
    t_event_code   n_res_code [0:2];
    logic [1:0]    r_res_cnt, n_res_cnt;
    logic [1:0]    r_res_idx, n_res_idx;

    // line memory and walk
    logic [7:0]    r_line_mem [0:LINE_DEPTH-1];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_pipe_vld, n_pipe_vld;
    logic [CW-1:0] r_pipe_pos, n_pipe_pos;
    logic          r_seen, n_seen;
    logic [CW-1:0] r_first, n_first;
    logic [CW-1:0] r_end, n_end;
    logic          r_mis, n_mis;

    // output register
    logic          r_out_valid, n_out_valid;
    logic          r_kind, n_kind;
    logic [7:0]    r_echo, n_echo;
    t_event_code   r_code, n_code;
    logic          r_logged, n_logged;
    logic          r_last, n_last;

    // combinational helpers
    logic          w_we;
    logic [7:0]    w_wdata;
    logic          w_clear;
    logic          w_ev_push;
    t_event_code   w_ev_code;
    logic          w_echo_push;
    logic [7:0]    w_echo_byte;
    logic          w_bs_push;
    logic          w_entry;
    logic [3:0]    w_len_sat;
    logic [63:0]   w_text;
    logic [CW-1:0] w_off;
    logic          w_cmp;
    logic [7:0]    w_char;
    logic [CW-1:0] w_trim_len;
    logic          w_match;
    logic [7:0]    w_failed_inc;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_echo_byte  = r_echo;
    assign o_event_code = r_code;
    assign o_logged_in  = r_logged;
    assign o_last       = r_last;

    assign w_entry = (r_auth == ST_USER) || (r_auth == ST_PASS);

    // credential selected by stage, length clipped to the credential width
    always_comb begin
        if (r_auth == ST_PASS) begin
            w_text    = r_pass_text;
            w_len_sat = (r_pass_len > CRED_LEN) ? CRED_LEN : r_pass_len;
        end else begin
            w_text    = r_user_text;
            w_len_sat = (r_user_len > CRED_LEN) ? CRED_LEN : r_user_len;
        end
    end

    // offset of the walked character inside the trimmed line
    always_comb begin
        w_off = '0;
        w_cmp = 1'b0;
        if (r_seen) begin
            w_off = r_pipe_pos - r_first;
            w_cmp = 1'b1;
        end else if (r_rd_data != CH_SPACE) begin
            w_cmp = 1'b1;
        end
        w_char = w_text[{w_off[2:0], 3'b000} +: 8];
    end

    assign w_trim_len   = r_seen ? (r_end - r_first) : '0;
    assign w_match      = !r_mis && (w_trim_len == CW'(w_len_sat));
    assign w_failed_inc = (r_failed == 8'hFF) ? 8'hFF : (r_failed + 8'd1);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_auth      = r_auth;
        n_esc       = r_esc;
        n_count     = r_count;
        n_failed    = r_failed;
        n_ticks     = r_ticks;
        n_open      = r_open;
        n_res_kind  = r_res_kind;
        n_res_byte  = r_res_byte;
        n_res_code  = r_res_code;
        n_res_cnt   = r_res_cnt;
        n_res_idx   = r_res_idx;
        n_rd_idx    = r_rd_idx;
        n_pipe_vld  = 1'b0;
        n_pipe_pos  = r_pipe_pos;
        n_seen      = r_seen;
        n_first     = r_first;
        n_end       = r_end;
        n_mis       = r_mis;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_echo      = r_echo;
        n_code      = r_code;
        n_logged    = r_logged;
        n_last      = r_last;
        w_we        = 1'b0;
        w_wdata     = i_data_byte;
        w_clear     = 1'b0;
        w_ev_push   = 1'b0;
        w_ev_code   = EV_NONE;
        w_echo_push = 1'b0;
        w_echo_byte = i_data_byte;
        w_bs_push   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_CONNECT: begin
                            w_clear   = 1'b1;
                            n_open    = 1'b1;
                            w_ev_push = 1'b1;
                            w_ev_code = EV_PROMPT;
                        end
                        CMD_DISCONNECT: begin
                            w_clear = 1'b1;
                            n_open  = 1'b0;
                        end
                        CMD_TICK: begin
                            if (r_open && r_auth != ST_IN) begin
                                if (r_ticks >= r_timeout) begin
                                    w_clear   = 1'b1;
                                    n_open    = 1'b0;
                                    w_ev_push = 1'b1;
                                    w_ev_code = EV_KICK_TIMEOUT;
                                end else begin
                                    n_ticks = r_ticks + 16'd1;
                                end
                            end
                        end
                        CMD_BYTE: begin
                            if (r_open) begin
                                if (r_esc == ESC_IAC) begin
                                    n_esc = (i_data_byte >= CH_OPT_LO && i_data_byte <= CH_OPT_HI)
                                          ? ESC_OPT : ESC_NONE;
                                end else if (r_esc == ESC_OPT) begin
                                    n_esc = ESC_NONE;
                                end else begin
                                    n_esc = ESC_NONE;
                                    if (i_data_byte == CH_IAC) begin
                                        n_esc = ESC_IAC;
                                    end else if (i_data_byte == CH_CR || i_data_byte == CH_LF) begin
                                        if (r_count != '0) begin
                                            if (w_entry) begin
                                                n_rd_idx = '0;
                                                n_seen   = 1'b0;
                                                n_first  = '0;
                                                n_end    = '0;
                                                n_mis    = 1'b0;
                                                n_state  = S_WALK;
                                            end else begin
                                                n_count = '0;
                                            end
                                        end
                                    end else if (i_data_byte == CH_BS || i_data_byte == CH_DEL) begin
                                        if (r_count != '0) begin
                                            n_count   = r_count - CW'(1);
                                            w_bs_push = w_entry;
                                        end
                                    end else if (i_data_byte >= CH_SPACE && i_data_byte < CH_DEL) begin
                                        if (r_count < DEPTH_C) begin
                                            w_we    = 1'b1;
                                            n_count = r_count + CW'(1);
                                            if (r_auth == ST_USER) begin
                                                w_echo_push = 1'b1;
                                            end else if (r_auth == ST_PASS) begin
                                                w_echo_push = 1'b1;
                                                w_echo_byte = CH_STAR;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                // one read a cycle, data returns next cycle
                n_pipe_vld = 1'b1;
                n_pipe_pos = r_rd_idx;
                n_rd_idx   = r_rd_idx + CW'(1);
                if ((r_rd_idx + CW'(1)) == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_count   = '0;
                w_ev_push = 1'b1;
                if (w_match) begin
                    if (r_auth == ST_USER) begin
                        n_auth    = ST_PASS;
                        w_ev_code = EV_ASK_PASS;
                    end else begin
                        n_auth    = ST_IN;
                        w_ev_code = EV_LOGIN_OK;
                    end
                end else begin
                    n_failed = w_failed_inc;
                    if (w_failed_inc >= r_max_att) begin
                        w_clear   = 1'b1;
                        n_open    = 1'b0;
                        w_ev_code = EV_KICK_ATTEMPT;
                    end else begin
                        n_auth    = ST_USER;
                        w_ev_code = (r_auth == ST_USER) ? EV_BAD_USER : EV_BAD_PASS;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_kind      = r_res_kind[r_res_idx];
                    n_echo      = r_res_byte[r_res_idx];
                    n_code      = r_res_code[r_res_idx];
                    n_logged    = r_open && (r_auth == ST_IN);
                    n_last      = (r_res_idx == (r_res_cnt - 2'd1));
                    n_res_idx   = r_res_idx + 2'd1;
                    if (r_res_idx == (r_res_cnt - 2'd1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // trimmed compare of the returned line character
        if (r_pipe_vld) begin
            if (r_rd_data != CH_SPACE) begin
                if (!r_seen) begin
                    n_seen  = 1'b1;
                    n_first = r_pipe_pos;
                end
                n_end = r_pipe_pos + CW'(1);
            end
            if (w_cmp && (w_off < CW'(w_len_sat)) && (r_rd_data != w_char)) begin
                n_mis = 1'b1;
            end
        end

        // session clear
        if (w_clear) begin
            n_auth   = ST_USER;
            n_esc    = ESC_NONE;
            n_count  = '0;
            n_failed = 8'd0;
            n_ticks  = 16'd0;
        end

        // result buffer fill
        if (w_ev_push) begin
            n_res_kind[0] = KIND_EVENT;
            n_res_byte[0] = 8'h00;
            n_res_code[0] = w_ev_code;
            n_res_cnt     = 2'd1;
        end else if (w_echo_push) begin
            n_res_kind[0] = KIND_ECHO;
            n_res_byte[0] = w_echo_byte;
            n_res_code[0] = EV_NONE;
            n_res_cnt     = 2'd1;
        end else if (w_bs_push) begin
            n_res_kind[0] = KIND_ECHO;
            n_res_byte[0] = CH_BS;
            n_res_code[0] = EV_NONE;
            n_res_kind[1] = KIND_ECHO;
            n_res_byte[1] = CH_SPACE;
            n_res_code[1] = EV_NONE;
            n_res_kind[2] = KIND_ECHO;
            n_res_byte[2] = CH_BS;
            n_res_code[2] = EV_NONE;
            n_res_cnt     = 2'd3;
        end
        if (w_ev_push || w_echo_push || w_bs_push) begin
            n_res_idx = 2'd0;
            n_state   = S_EMIT;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_text <= '0;
            r_user_len  <= '0;
            r_pass_text <= '0;
            r_pass_len  <= '0;
            r_max_att   <= MAX_ATT_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_USER_TEXT: r_user_text <= i_cfg_data;
                REG_USER_LEN:  r_user_len  <= i_cfg_data[3:0];
                REG_PASS_TEXT: r_pass_text <= i_cfg_data;
                REG_PASS_LEN:  r_pass_len  <= i_cfg_data[3:0];
                REG_MAX_ATT:   r_max_att   <= i_cfg_data[7:0];
                REG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_auth      <= ST_USER;
            r_esc       <= ESC_NONE;
            r_count     <= '0;
            r_failed    <= '0;
            r_ticks     <= '0;
            r_open      <= 1'b0;
            r_res_cnt   <= '0;
            r_res_idx   <= '0;
            r_rd_idx    <= '0;
            r_pipe_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_auth      <= n_auth;
            r_esc       <= n_esc;
            r_count     <= n_count;
            r_failed    <= n_failed;
            r_ticks     <= n_ticks;
            r_open      <= n_open;
            r_res_cnt   <= n_res_cnt;
            r_res_idx   <= n_res_idx;
            r_rd_idx    <= n_rd_idx;
            r_pipe_vld  <= n_pipe_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walk trackers
    always_ff @(posedge i_clk) begin
        r_res_kind <= n_res_kind;
        r_res_byte <= n_res_byte;
        r_res_code <= n_res_code;
        r_pipe_pos <= n_pipe_pos;
        r_seen     <= n_seen;
        r_first    <= n_first;
        r_end      <= n_end;
        r_mis      <= n_mis;
        r_kind     <= n_kind;
        r_echo     <= n_echo;
        r_code     <= n_code;
        r_logged   <= n_logged;
        r_last     <= n_last;
    end

    // line memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_line_mem[r_count[AW-1:0]] <= w_wdata;
        end
        r_rd_data <= r_line_mem[r_rd_idx[AW-1:0]];
    end

endmodule

FILE: hdl/telnet_login_line_parser_checker.sv
// port-level checks of the telnet login line parser and their bind
`include "telnet_login_line_parser_assert.svh"

module telnet_login_line_parser_checker
    import tlp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_kind,
    input logic [7:0] o_echo_byte,
    input logic [2:0] o_event_code,
    input logic       o_logged_in,
    input logic       o_last
);

    // a stalled result transfer keeps its payload
    `TLP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_echo_byte) && $stable(o_event_code) && $stable(o_last))

    // echoes carry no event, events carry a code and no byte
    `TLP_ASSERT_SAME(a_kind_fields, o_out_valid, (o_kind == KIND_ECHO) ? (o_event_code == EV_NONE) : (o_echo_byte == 8'h00 && o_event_code != EV_NONE))

    // no echo once the session is authenticated
    `TLP_ASSERT_SAME(a_no_echo_logged, o_out_valid && o_kind == KIND_ECHO, !o_logged_in)

    // a successful login is a single result and marks the session
    `TLP_ASSERT_SAME(a_login_ok, o_out_valid && o_kind == KIND_EVENT && o_event_code == EV_LOGIN_OK, o_logged_in && o_last)

    // the prompt after connect is a single result of a fresh session
    `TLP_ASSERT_SAME(a_prompt, o_out_valid && o_kind == KIND_EVENT && o_event_code == EV_PROMPT, o_last && !o_logged_in)

endmodule

bind telnet_login_line_parser telnet_login_line_parser_checker u_checker (.*);
